FILE: hw/rtl/rmq_pkg.sv
// Shared types and constants for the rotation matrix to quaternion pipeline.
`default_nettype none

package rmq_pkg;

    localparam int DATA_W = 16;   // width of every matrix element and quaternion part
    localparam int NUM_W  = 17;   // signed width of an off-diagonal sum or difference
    localparam int MAG_W  = 17;   // magnitude of such a sum or difference
    localparam int LANES  = 3;    // parts that need a division in every branch
    localparam int BR_W   = 2;

    typedef enum logic [BR_W-1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } branch_t;

    // Stage handshake shared by the square-root and divider sections.
    typedef struct packed {
        logic en;
        logic valid;
    } pipe_ctl_t;

endpackage

`default_nettype wire

FILE: hw/rtl/rotation_matrix_to_quaternion.sv
// Rotation matrix to unit quaternion (four-branch method), fully pipelined.
//
// Usage: one 3x3 rotation matrix per transfer on the s_ channel (nine signed
// Q1.FRAC_BITS elements, m00 in the lowest bits of s_tdata), one quaternion per
// transfer on the m_ channel (w, x, y, z in m_tdata, branch and degenerate flag
// in m_tuser). Every input transfer yields exactly one output transfer, in order.
// Throughput: one matrix per cycle while the receiver keeps m_tready high; items overlap freely in the pipeline.
// Stages: input register, branch and radicand register, RS square-root stages, QW
// divider stages, result register and output register, where RS is the square-root
// stage count and QW the divider stage count (16 and 31 at FRAC_BITS = 14). Both
// counts depend on FRAC_BITS; the divider, one quotient bit per stage, is longest.
// Reset: aresetn low clears every valid bit; items in flight are dropped.
// Stall: the output register is backed by a one-entry skid register. While the
// receiver holds m_tready low, the pipeline keeps advancing until one result
// waits in the skid register; then s_tready drops and all stages hold.
// A zero divisor (non-positive radicand) forces the four parts to zero and sets
// the degenerate flag; the branch code still names the chosen branch.
`default_nettype none

module rotation_matrix_to_quaternion
    import rmq_pkg::*;
#(
    parameter int FRAC_BITS = 14
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // m00, m01, m02, m10, m11, m12, m20, m21, m22 (16 bits each, lowest first)
    input  wire logic [143:0]  s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // quat_w, quat_x, quat_y, quat_z (16 bits each, lowest first)
    output logic [63:0]        m_tdata,
    // branch_taken [1:0], degenerate [2]
    output logic [2:0]         m_tuser
);

    localparam int FX    = (FRAC_BITS > DATA_W) ? FRAC_BITS : DATA_W;
    localparam int RADW  = FX + 2;                 // signed radicand before scaling
    localparam int RS    = (RADW + FRAC_BITS + 1) / 2;
    localparam int SQW   = 2 * RS;
    localparam int QW    = MAG_W + FRAC_BITS;      // dividend and quotient width
    localparam int DW    = RS + 1;                 // divisor is twice the root
    localparam int SQ_SB = BR_W + LANES * NUM_W;
    localparam int DV_SB = BR_W + LANES + RS;
    localparam int NELEM = 9;

    localparam logic signed [RADW-1:0] ONE_R = RADW'(1) << FRAC_BITS;
    localparam logic [QW-1:0]          ONE_Q = QW'(1) << FRAC_BITS;

    pipe_ctl_t ctl_sq, ctl_dv;
    logic      en;
    logic      skid_valid_reg;

    // ---------------------------------------------------------------
    // Advance: every stage moves while the skid register is empty.
    // ---------------------------------------------------------------
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // Input register
    logic                     in_valid_reg;
    logic signed [DATA_W-1:0] m_reg [NELEM];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NELEM; i++) begin
                m_reg[i] <= s_tdata[i*DATA_W +: DATA_W];
            end
        end
    end

    // ---------------------------------------------------------------
    // Branch selection, radicand and the three numerators.
    // ---------------------------------------------------------------
    logic signed [RADW-1:0] e [NELEM];
    logic signed [RADW-1:0] trace, rad, n0, n1, n2;
    logic [SQW-1:0]         rad_scaled;
    branch_t                br_sel;

    always_comb begin
        for (int i = 0; i < NELEM; i++) begin
            e[i] = RADW'(m_reg[i]);
        end
        trace = e[0] + e[4] + e[8];
        if (trace > 0) begin
            br_sel = BR_TRACE;
            rad    = trace + ONE_R;
            n0     = e[7] - e[5];
            n1     = e[2] - e[6];
            n2     = e[3] - e[1];
        end else if (e[0] > e[4] && e[0] > e[8]) begin
            br_sel = BR_X;
            rad    = ONE_R + e[0] - e[4] - e[8];
            n0     = e[7] - e[5];
            n1     = e[1] + e[3];
            n2     = e[2] + e[6];
        end else if (e[4] > e[8]) begin
            br_sel = BR_Y;
            rad    = ONE_R + e[4] - e[0] - e[8];
            n0     = e[2] - e[6];
            n1     = e[1] + e[3];
            n2     = e[5] + e[7];
        end else begin
            br_sel = BR_Z;
            rad    = ONE_R + e[8] - e[0] - e[4];
            n0     = e[3] - e[1];
            n1     = e[2] + e[6];
            n2     = e[5] + e[7];
        end
        // Drop non-positive radicands to zero: the root is then zero too.
        if (rad > 0) begin
            rad_scaled = SQW'(rad[RADW-2:0]) << FRAC_BITS;
        end else begin
            rad_scaled = '0;
        end
    end

    logic              prep_valid_reg;
    logic [SQW-1:0]    prep_rad_reg;
    logic [SQ_SB-1:0]  prep_sb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prep_valid_reg <= 1'b0;
        end else if (en) begin
            prep_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prep_rad_reg <= rad_scaled;
            prep_sb_reg  <= {br_sel, n2[NUM_W-1:0], n1[NUM_W-1:0], n0[NUM_W-1:0]};
        end
    end

    // ---------------------------------------------------------------
    // Square root
    // ---------------------------------------------------------------
    logic             sq_valid;
    logic [RS-1:0]    sq_root;
    logic [SQ_SB-1:0] sq_sb;

    assign ctl_sq.en    = en;
    assign ctl_sq.valid = prep_valid_reg;

    rmq_isqrt_pipe #(
        .RS   (RS),
        .SB_W (SQ_SB)
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (ctl_sq),
        .in_rad    (prep_rad_reg),
        .in_sb     (prep_sb_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_sb    (sq_sb)
    );

    // Split numerators into sign and magnitude, scale into the dividend.
    logic [LANES-1:0][QW-1:0] dv_num;
    logic [LANES-1:0]         sq_neg;
    logic [BR_W-1:0]          sq_br;

    always_comb begin
        logic [NUM_W-1:0] n;
        logic [MAG_W-1:0] mag;
        sq_br = sq_sb[SQ_SB-1 -: BR_W];
        for (int l = 0; l < LANES; l++) begin
            n         = sq_sb[l*NUM_W +: NUM_W];
            sq_neg[l] = n[NUM_W-1];
            mag       = sq_neg[l] ? MAG_W'(~n + 1'b1) : MAG_W'(n);
            dv_num[l] = {mag, {FRAC_BITS{1'b0}}};
        end
    end

    // ---------------------------------------------------------------
    // Division of the three numerators by 2 * root
    // ---------------------------------------------------------------
    logic                     dv_valid;
    logic [LANES-1:0][QW-1:0] dv_quo;
    logic [DV_SB-1:0]         dv_sb;

    assign ctl_dv.en    = en;
    assign ctl_dv.valid = sq_valid;

    rmq_div_pipe #(
        .QW   (QW),
        .DW   (DW),
        .SB_W (DV_SB)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (ctl_dv),
        .in_num    (dv_num),
        .in_den    ({sq_root, 1'b0}),
        .in_sb     ({sq_br, sq_neg, sq_root}),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_sb    (dv_sb)
    );

    // ---------------------------------------------------------------
    // Saturate, restore signs and place the parts by branch.
    // ---------------------------------------------------------------
    logic [RS-1:0]             f_root;
    logic [LANES-1:0]          f_neg;
    branch_t                   f_br;
    logic [DATA_W-1:0]         lane_v [LANES];
    logic [DATA_W-1:0]         w_v;
    logic [QW-1:0]             w_half;
    logic                      f_degen;
    logic [4*DATA_W-1:0]       f_data;

    always_comb begin
        logic [QW-1:0]     qs;
        logic [DATA_W-1:0] v16;
        f_root = dv_sb[RS-1:0];
        f_neg  = dv_sb[RS +: LANES];
        f_br   = branch_t'(dv_sb[DV_SB-1 -: BR_W]);
        for (int l = 0; l < LANES; l++) begin
            qs        = (dv_quo[l] > ONE_Q) ? ONE_Q : dv_quo[l];
            v16       = qs[DATA_W-1:0];
            lane_v[l] = f_neg[l] ? (~v16 + 1'b1) : v16;
        end
        w_half  = QW'(f_root >> 1);
        w_v     = (w_half > ONE_Q) ? ONE_Q[DATA_W-1:0] : w_half[DATA_W-1:0];
        f_degen = (f_root == '0);
        unique case (f_br)
            BR_TRACE: f_data = {lane_v[2], lane_v[1], lane_v[0], w_v};
            BR_X:     f_data = {lane_v[2], lane_v[1], w_v, lane_v[0]};
            BR_Y:     f_data = {lane_v[2], w_v, lane_v[1], lane_v[0]};
            BR_Z:     f_data = {w_v, lane_v[2], lane_v[1], lane_v[0]};
            default:  f_data = '0;
        endcase
        if (f_degen) begin
            f_data = '0;
        end
    end

    logic               fin_valid_reg;
    logic [63:0]        fin_data_reg;
    logic [2:0]         fin_user_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (en) begin
            fin_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_data_reg <= f_data;
            fin_user_reg <= {f_degen, f_br};
        end
    end

    // ---------------------------------------------------------------
    // Output register with skid entry
    // ---------------------------------------------------------------
    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg, skid_data_reg;
    logic [2:0]  m_tuser_reg, skid_user_reg;
    logic        m_take;

    assign m_take = m_tvalid_reg && m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg   <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            // Pipeline holds; drain the skid entry once the output moves.
            if (m_take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (fin_valid_reg) begin
            if (!m_tvalid_reg || m_take) begin
                m_tvalid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_take) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_take) begin
                m_tdata_reg <= skid_data_reg;
                m_tuser_reg <= skid_user_reg;
            end
        end else if (fin_valid_reg) begin
            if (!m_tvalid_reg || m_take) begin
                m_tdata_reg <= fin_data_reg;
                m_tuser_reg <= fin_user_reg;
            end else begin
                skid_data_reg <= fin_data_reg;
                skid_user_reg <= fin_user_reg;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/rmq_isqrt_pipe.sv
// Pipelined integer square root, one result bit per stage, with a sideband.
`default_nettype none

module rmq_isqrt_pipe
    import rmq_pkg::*;
#(
    parameter int RS   = 16,
    parameter int SB_W = 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire pipe_ctl_t         in_ctl,
    input  wire logic [2*RS-1:0]   in_rad,
    input  wire logic [SB_W-1:0]   in_sb,
    output logic                   out_valid,
    output logic [RS-1:0]          out_root,
    output logic [SB_W-1:0]        out_sb
);

    localparam int SQW = 2 * RS;

    logic [SQW-1:0]  rem_w [RS+1];
    logic [SQW-1:0]  r_w   [RS+1];
    logic [SB_W-1:0] sb_w  [RS+1];
    logic            v_w   [RS+1];

    assign rem_w[0] = in_rad;
    assign r_w[0]   = '0;
    assign sb_w[0]  = in_sb;
    assign v_w[0]   = in_ctl.valid;

    for (genvar k = 0; k < RS; k++) begin : g_st
        localparam logic [SQW-1:0] BIT = SQW'(1) << (2 * (RS - 1 - k));

        logic [SQW:0]    trial;
        logic            ge;
        logic [SQW-1:0]  rem_next, r_next;
        logic [SQW-1:0]  rem_reg, r_reg;
        logic [SB_W-1:0] sb_reg;
        logic            v_reg;

        always_comb begin
            trial = {1'b0, r_w[k]} + {1'b0, BIT};
            ge    = ({1'b0, rem_w[k]} >= trial);
            if (ge) begin
                rem_next = rem_w[k] - trial[SQW-1:0];
                r_next   = (r_w[k] >> 1) + BIT;
            end else begin
                rem_next = rem_w[k];
                r_next   = r_w[k] >> 1;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (in_ctl.en) begin
                v_reg <= v_w[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (in_ctl.en) begin
                rem_reg <= rem_next;
                r_reg   <= r_next;
                sb_reg  <= sb_w[k];
            end
        end

        assign rem_w[k+1] = rem_reg;
        assign r_w[k+1]   = r_reg;
        assign sb_w[k+1]  = sb_reg;
        assign v_w[k+1]   = v_reg;
    end

    assign out_valid = v_w[RS];
    assign out_root  = r_w[RS][RS-1:0];
    assign out_sb    = sb_w[RS];

endmodule

`default_nettype wire

FILE: hw/rtl/rmq_div_pipe.sv
// Pipelined restoring divider, three lanes sharing one divisor, one bit per stage.
`default_nettype none

module rmq_div_pipe
    import rmq_pkg::*;
#(
    parameter int QW   = 31,
    parameter int DW   = 17,
    parameter int SB_W = 8
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire pipe_ctl_t                  in_ctl,
    input  wire logic [LANES-1:0][QW-1:0]   in_num,
    input  wire logic [DW-1:0]              in_den,
    input  wire logic [SB_W-1:0]            in_sb,
    output logic                            out_valid,
    output logic [LANES-1:0][QW-1:0]        out_quo,
    output logic [SB_W-1:0]                 out_sb
);

    logic [LANES-1:0][QW-1:0] num_w [QW+1];
    logic [LANES-1:0][QW-1:0] quo_w [QW+1];
    logic [LANES-1:0][DW-1:0] rem_w [QW+1];
    logic [DW-1:0]            den_w [QW+1];
    logic [SB_W-1:0]          sb_w  [QW+1];
    logic                     v_w   [QW+1];

    assign num_w[0] = in_num;
    assign quo_w[0] = '0;
    assign rem_w[0] = '0;
    assign den_w[0] = in_den;
    assign sb_w[0]  = in_sb;
    assign v_w[0]   = in_ctl.valid;

    for (genvar j = 0; j < QW; j++) begin : g_st
        logic [LANES-1:0][QW-1:0] quo_next, quo_reg, num_reg;
        logic [LANES-1:0][DW-1:0] rem_next, rem_reg;
        logic [DW-1:0]            den_reg;
        logic [SB_W-1:0]          sb_reg;
        logic                     v_reg;

        always_comb begin
            logic [DW:0] sh;
            logic        ge;
            for (int l = 0; l < LANES; l++) begin
                sh = {rem_w[j][l], num_w[j][l][QW-1-j]};
                ge = (sh >= {1'b0, den_w[j]});
                rem_next[l] = ge ? DW'(sh - {1'b0, den_w[j]}) : sh[DW-1:0];
                quo_next[l] = {quo_w[j][l][QW-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg <= 1'b0;
            end else if (in_ctl.en) begin
                v_reg <= v_w[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (in_ctl.en) begin
                num_reg <= num_w[j];
                quo_reg <= quo_next;
                rem_reg <= rem_next;
                den_reg <= den_w[j];
                sb_reg  <= sb_w[j];
            end
        end

        assign num_w[j+1] = num_reg;
        assign quo_w[j+1] = quo_reg;
        assign rem_w[j+1] = rem_reg;
        assign den_w[j+1] = den_reg;
        assign sb_w[j+1]  = sb_reg;
        assign v_w[j+1]   = v_reg;
    end

    assign out_valid = v_w[QW];
    assign out_quo   = quo_w[QW];
    assign out_sb    = sb_w[QW];

endmodule

`default_nettype wire

FILE: hw/rtl/rmq_checker.sv
// Port-level checks for the rotation matrix to quaternion block, bound to the top.
`default_nettype none

module rmq_checker
    import rmq_pkg::*;
(
    input wire logic          aclk,
    input wire logic          aresetn,
    input wire logic          s_tvalid,
    input wire logic          s_tready,
    input wire logic [143:0]  s_tdata,
    input wire logic          m_tvalid,
    input wire logic          m_tready,
    input wire logic [63:0]   m_tdata,
    input wire logic [2:0]    m_tuser
);

    // A stalled result holds its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A waiting input transfer holds its payload.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("waiting input changed");

    // Reset empties the output.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A degenerate result carries four zero parts.
    a_degen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[2] |-> m_tdata == '0)
        else $error("degenerate result with nonzero parts");

    // The trace branch always has a positive radicand.
    a_trace: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1:0] == BR_TRACE |-> !m_tuser[2])
        else $error("trace branch flagged degenerate");

endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (.*);

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking stream testbench for the rotation matrix to quaternion pipeline.
`default_nettype none

module testbench
    import rmq_pkg::*;
();

    localparam int ONE     = 16384;
    localparam int LATENCY = 50;
    localparam int N_RAND  = 450;

    typedef struct packed {
        logic signed [15:0] z;
        logic signed [15:0] y;
        logic signed [15:0] x;
        logic signed [15:0] w;
    } quat_t;

    typedef struct {
        quat_t   q;
        branch_t br;
        logic    degen;
    } quat_res_t;

    // Matrix elements, m00 first.
    typedef logic signed [15:0] mat_t [9];

    // One directed row; chk_fixed says the typed-in result is used.
    typedef struct {
        mat_t      m;
        logic      chk_fixed;
        quat_res_t fixed;
    } vec_row_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [2:0]   m_tuser;

    quat_res_t quat_q[$];
    int        n_err = 0;
    int        n_quat = 0;
    int        n_sent = 0;
    int        n_degen = 0;
    int        br_seen [4] = '{0, 0, 0, 0};
    bit        hold_rx = 1'b0;
    bit        stim_done = 1'b0;

    always #1 aclk = ~aclk;

    rotation_matrix_to_quaternion i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Integer square root, bit by bit.
    function automatic longint unsigned root_of(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // Clamp to [-1.0, 1.0] in Q1.14.
    function automatic logic signed [15:0] clamp_one(longint v);
        if (v > ONE) return 16'(ONE);
        if (v < -ONE) return 16'(-ONE);
        return 16'(v);
    endfunction

    // Signed fractional divide, truncated toward zero.
    function automatic longint frac_div(longint n, longint unsigned d);
        longint unsigned mag, q;
        mag = (n < 0) ? longint'(-n) : n;
        q = (mag << 14) / d;
        return (n < 0) ? -longint'(q) : longint'(q);
    endfunction

    // Predict the quaternion for one matrix.
    function automatic quat_res_t predict_quat(mat_t m);
        quat_res_t res;
        longint a [9];
        longint t, rad;
        longint num [4];
        longint part [4];
        longint unsigned r, d;
        int diag;
        for (int i = 0; i < 9; i++) a[i] = m[i];
        num = '{0, 0, 0, 0};
        t = a[0] + a[4] + a[8];
        if (t > 0) begin
            res.br = BR_TRACE; diag = 0; rad = t + ONE;
            num[1] = a[7] - a[5]; num[2] = a[2] - a[6]; num[3] = a[3] - a[1];
        end else if (a[0] > a[4] && a[0] > a[8]) begin
            res.br = BR_X; diag = 1; rad = ONE + a[0] - a[4] - a[8];
            num[0] = a[7] - a[5]; num[2] = a[1] + a[3]; num[3] = a[2] + a[6];
        end else if (a[4] > a[8]) begin
            res.br = BR_Y; diag = 2; rad = ONE + a[4] - a[0] - a[8];
            num[0] = a[2] - a[6]; num[1] = a[1] + a[3]; num[3] = a[5] + a[7];
        end else begin
            res.br = BR_Z; diag = 3; rad = ONE + a[8] - a[0] - a[4];
            num[0] = a[3] - a[1]; num[1] = a[2] + a[6]; num[2] = a[5] + a[7];
        end
        r = (rad > 0) ? root_of(longint'(rad) << 14) : 0;
        d = r * 2;
        res.degen = (d == 0);
        part = '{0, 0, 0, 0};
        if (!res.degen) begin
            for (int k = 0; k < 4; k++)
                part[k] = (k == diag) ? longint'(r >> 1) : frac_div(num[k], d);
        end
        res.q.w = clamp_one(part[0]);
        res.q.x = clamp_one(part[1]);
        res.q.y = clamp_one(part[2]);
        res.q.z = clamp_one(part[3]);
        return res;
    endfunction

    // Offer one matrix with an optional gap before it; return after the transfer.
    task automatic send_matrix(mat_t m, quat_res_t exp_res, bit gap);
        int idle;
        idle = 0;
        if (gap) idle = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2)
                                                  : $urandom_range(5, 30);
        if (idle > 0) begin
            s_tvalid <= 1'b0;
            repeat (idle) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        for (int i = 0; i < 9; i++) s_tdata[16*i +: 16] <= m[i];
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        quat_q.push_back(exp_res);
        n_sent++;
    endtask

    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return 16'(ONE);
            1: return 16'(-ONE);
            2: return 16'($urandom());   // full 16-bit noise, out of range too
            default: return 16'(int'($urandom_range(0, 2*ONE)) - ONE);
        endcase
    endfunction

    // Mostly near-rotation shapes: a positive trace or a dominant diagonal entry picks the branch.
    function automatic mat_t rand_matrix();
        mat_t m;
        int pick;
        for (int i = 0; i < 9; i++) m[i] = rand_elem();
        pick = $urandom_range(0, 5);
        if (pick < 4) begin
            for (int i = 0; i < 9; i++) m[i] = 16'(int'($urandom_range(0, 8000)) - 4000);
            if (pick == 0) begin
                m[0] = 16'($urandom_range(4000, ONE));
                m[4] = 16'($urandom_range(4000, ONE));
                m[8] = 16'($urandom_range(0, ONE));
            end else begin
                m[0] = 16'(-int'($urandom_range(2000, ONE)));
                m[4] = 16'(-int'($urandom_range(2000, ONE)));
                m[8] = 16'(-int'($urandom_range(2000, ONE)));
                m[(pick-1)*4] = 16'($urandom_range(0, ONE));
            end
        end
        return m;
    endfunction

    // Receiver: random stalls, plus a long hold-off when asked.
    initial begin
        m_tready <= 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (hold_rx) m_tready <= 1'b0;
            else if ($urandom_range(0, 3) == 0) m_tready <= 1'b0;
            else if ($urandom_range(0, 99) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge aclk);
                m_tready <= 1'b1;
            end else m_tready <= 1'b1;
        end
    end

    // Check each result transfer against the oldest prediction.
    always @(posedge aclk) begin
        quat_res_t want;
        quat_t     got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            n_quat++;
            if (quat_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("ERROR: result with none expected: %h %h",
                                          m_tdata, m_tuser);
            end else begin
                want = quat_q.pop_front();
                br_seen[want.br]++;
                if (want.degen) n_degen++;
                if (got !== want.q || m_tuser[1:0] !== want.br
                    || m_tuser[2] !== want.degen) begin
                    n_err++;
                    if (n_err <= 10)
                        $display("ERROR: quat %0d exp w%0d x%0d y%0d z%0d br%0d dg%0b",
                                 n_quat, want.q.w, want.q.x, want.q.y, want.q.z,
                                 want.br, want.degen,
                                 " got w%0d x%0d y%0d z%0d br%0d dg%0b",
                                 got.w, got.x, got.y, got.z, m_tuser[1:0], m_tuser[2]);
                end
            end
        end
    end

    // Stimulus.
    initial begin
        vec_row_t rows [$];
        vec_row_t row;
        quat_res_t zero_res;
        quat_res_t exp_res;
        mat_t m;
        zero_res.q = '0;
        zero_res.degen = 1'b0;
        zero_res.br = BR_TRACE;

        // Identity: w = 1.0, rest zero.
        row.m = '{16'(ONE), 0, 0, 0, 16'(ONE), 0, 0, 0, 16'(ONE)};
        row.chk_fixed = 1'b1; row.fixed = zero_res; row.fixed.q.w = 16'(ONE);
        rows.push_back(row);
        // Zero matrix: trace 0, ties pick m22, radicand 1.0.
        row.m = '{default: 0}; row.chk_fixed = 1'b0; rows.push_back(row);
        // All -1: z branch, radicand 2.0, result predicted.
        row.m = '{default: 16'(-ONE)}; rows.push_back(row);
        // Tie between m00 and m22 above m11: the m22 branch is taken.
        row.m = '{16'(-ONE/2), 0, 0, 0, 16'(-ONE), 0, 0, 0, 16'(-ONE/2)};
        rows.push_back(row);
        // Out-of-range diagonal with a positive trace.
        row.m = '{-16'sd32768, 0, 0, 0, 16'sd32767, 0, 0, 0, 16'sd32767};
        row.chk_fixed = 1'b0; rows.push_back(row);
        // 180 degree rotations around x, y, z.
        row.m = '{16'(ONE), 0, 0, 0, 16'(-ONE), 0, 0, 0, 16'(-ONE)};
        row.chk_fixed = 1'b1; row.fixed = zero_res; row.fixed.br = BR_X;
        row.fixed.q.x = 16'(ONE);
        rows.push_back(row);
        row.m = '{16'(-ONE), 0, 0, 0, 16'(ONE), 0, 0, 0, 16'(-ONE)};
        row.fixed = zero_res; row.fixed.br = BR_Y; row.fixed.q.y = 16'(ONE);
        rows.push_back(row);
        row.m = '{16'(-ONE), 0, 0, 0, 16'(-ONE), 0, 0, 0, 16'(ONE)};
        row.fixed = zero_res; row.fixed.br = BR_Z; row.fixed.q.z = 16'(ONE);
        rows.push_back(row);
        // Diagonal ties: m00 = m11 > m22, then m11 = m22.
        row.chk_fixed = 1'b0;
        row.m = '{-16'sd100, 1, 2, 3, -16'sd100, 5, 6, 7, -16'sd9000}; rows.push_back(row);
        row.m = '{-16'sd9000, 1, 2, 3, -16'sd100, 5, 6, 7, -16'sd100}; rows.push_back(row);
        // Raw extremes of the field encoding; saturation on the off-diagonals.
        row.m = '{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767,
                  -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767};
        rows.push_back(row);
        row.m = '{-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768,
                  16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768};
        rows.push_back(row);
        row.m = '{1, -16'sd32768, 16'sd32767, 16'sd32767, 0, -16'sd32768,
                  -16'sd32768, 16'sd32767, 0};
        rows.push_back(row);
        // 90 degrees about z.
        row.m = '{0, 16'(-ONE), 0, 16'(ONE), 0, 0, 0, 0, 16'(ONE)}; rows.push_back(row);
        // Trace just positive.
        row.m = '{1, 0, 0, 0, 0, 0, 0, 0, 0}; rows.push_back(row);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            exp_res = predict_quat(rows[i].m);
            if (rows[i].chk_fixed && (exp_res.q !== rows[i].fixed.q
                                      || exp_res.br !== rows[i].fixed.br
                                      || exp_res.degen !== rows[i].fixed.degen)) begin
                n_err++;
                $display("ERROR: directed row %0d disagrees with hand value", i);
            end
            send_matrix(rows[i].m, rows[i].chk_fixed ? rows[i].fixed : exp_res, 1'b0);
        end

        // Hold the receiver long enough to fill the pipe and stall the input.
        hold_rx = 1'b1;
        fork
            repeat (3 * LATENCY) @(posedge aclk);
            for (int i = 0; i < 80; i++) begin
                m = rand_matrix();
                send_matrix(m, predict_quat(m), 1'b0);
            end
        join_any
        hold_rx = 1'b0;
        wait fork;

        for (int i = 0; i < N_RAND - 80; i++) begin
            m = rand_matrix();
            // Burst stretches without gaps, then gappy stretches.
            send_matrix(m, predict_quat(m), bit'((i / 40) % 2));
            if (i == 200) begin
                // Let the pipe drain completely before going on.
                s_tvalid <= 1'b0;
                while (quat_q.size() != 0) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b0;

        while (quat_q.size() != 0) @(posedge aclk);
        repeat (LATENCY + 10) @(posedge aclk);
        $display("Sent %0d matrices, checked %0d quaternions (%0d degenerate).",
                 n_sent, n_quat, n_degen);
        $display("Branches: trace %0d, x %0d, y %0d, z %0d; mismatches %0d.",
                 br_seen[0], br_seen[1], br_seen[2], br_seen[3], n_err);
        if (n_err == 0 && quat_q.size() == 0)
            $display("PASS rotation_matrix_to_quaternion");
        else
            $display("FAIL rotation_matrix_to_quaternion");
        $finish;
    end

    // Watchdog.
    initial begin
        #400000;
        $display("FAIL rotation_matrix_to_quaternion");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_isqrt_pipe.sv
hw/rtl/rmq_div_pipe.sv
hw/rtl/rotation_matrix_to_quaternion.sv
hw/rtl/rmq_checker.sv
verif/testbench.sv
